@@ rtl/ile_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Operation and status codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ile_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_INSERT  = 4'd1,
    OP_REPLACE = 4'd2,
    OP_REMOVE  = 4'd3,
    OP_READ    = 4'd4,
    OP_FIRST   = 4'd5,
    OP_LAST    = 4'd6,
    OP_SWAP    = 4'd7,
    OP_CLEAR   = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOMATCH = 3'd3,
    ST_WINDOW  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SEARCH,
    S_SEARCH_CHK,
    S_READ,
    S_READ_DONE,
    S_SWAP_RD,
    S_SWAP_WR,
    S_OUT
  } state_e;

  localparam int unsigned AddrW = 12;

  // Controller to datapath.
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [1:0]       wr_sel;   // 0 input item, 1 read data, 2 swap holding
    logic             hold_en;  // capture read data into the holding register
    logic             res_en;   // capture read data as result item
    logic             res_new;  // set result item to the masked input item
    logic             res_zero; // clear result item
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic match;  // compare of the last read word against the key
  } dp_sts_t;

  function automatic logic [3:0] eff_bytes(input logic [3:0] b, input int unsigned maxb);
    logic [3:0] r;
    r = b;
    if (r == 4'd0) r = 4'd1;
    if (r > 4'(maxb)) r = 4'(maxb);
    return r;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < nb) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

@@ rtl/indexed_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered item list with positional edits and search
// Stores up to CAPACITY items and serves append, insert, replace, remove,
// read, first and last match search, swap and clear requests.
// ----------------------------------------------------------------------------
// Usage:
// A request word enters on the s_axis group; it is held by the sender until
// its result word has been taken on the m_axis group, and the request is
// accepted in the same cycle the result is taken, so one request is in
// flight at a time. The result is held on m_axis while m_axis_tready is low.
// Append, replace, clear and rejected requests go from decode straight to
// the result; read adds a read step, swap two reads and two writes. Insert
// and remove shift every entry between the position and the end of the
// list, and a search visits entries until a hit or the end of the list.
// Every entry walked takes a read step and a write or compare step.
// The item_bytes register sits on the APB port at address 0; write it
// only while no request is pending. Reset empties the list, sets the last
// search index to -1 and item_bytes to 8; memory contents are left as is.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
  parameter int unsigned CAPACITY       = 256,
  parameter int unsigned MAX_ITEM_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // op[3:0], position[11:4], position_b[19:12], item_data[83:20],
  // match_offset[87:84], match_length[91:88], string_compare[92], zeros
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[2:0], result_item[66:3], result_index[74:67], entry_count[83:75],
  // last_search_index[92:84], zeros
  output logic [95:0]  m_axis_tdata_o,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [1:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [3:0] item_bytes_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) item_bytes_q <= 4'd8;
    else if (psel_i && penable_i && pwrite_i && paddr_i == 2'd0)
      item_bytes_q <= pwdata_i[3:0];
  end
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == 2'd0) ? {28'd0, item_bytes_q} : 32'd0;

  logic [3:0]  nb;
  logic [63:0] mask;
  assign nb   = ile_pkg::eff_bytes(item_bytes_q, MAX_ITEM_BYTES);
  assign mask = ile_pkg::byte_mask(nb);

  ile_pkg::dp_cmd_t cmd;
  ile_pkg::dp_sts_t sts;
  ile_pkg::status_e status;
  logic [63:0] res_item;
  logic [7:0]  res_idx;
  logic [8:0]  count, last;
  logic [3:0]  len_eff;

  ile_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .op_i        (s_axis_tdata_i[3:0]),
    .pa_i        (s_axis_tdata_i[11:4]),
    .pb_i        (s_axis_tdata_i[19:12]),
    .nb_i        (nb),
    .off_i       (s_axis_tdata_i[87:84]),
    .len_i       (s_axis_tdata_i[91:88]),
    .len_o       (len_eff),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .status_o    (status),
    .index_o     (res_idx),
    .count_o     (count),
    .last_o      (last)
  );

  ile_datapath #(.CAPACITY(CAPACITY), .AW(AW)) u_dp (
    .clk_i,
    .cmd_i    (cmd),
    .item_i   (s_axis_tdata_i[83:20]),
    .mask_i   (mask),
    .off_i    (s_axis_tdata_i[87:84]),
    .len_i    (len_eff),
    .str_i    (s_axis_tdata_i[92]),
    .sts_o    (sts),
    .result_o (res_item)
  );

  assign m_axis_tdata_o = {3'd0, last, count, res_idx, res_item, status};

  // The item count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[83:75] <= 9'(CAPACITY)))
    else $error("item count above capacity");

  // A request is only taken together with its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (m_axis_tvalid_o && m_axis_tready_i))
    else $error("request accepted without result");

  // A failed search leaves the last search index at -1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (status == ile_pkg::ST_NOMATCH || status == ile_pkg::ST_WINDOW))
    |-> (last == 9'h1FF))
    else $error("last search index set on failed search");

endmodule

@@ rtl/ile_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_datapath: item memory and window compare
// One write and one registered read port, a holding register for swaps and
// the key window compare of the last word read.
// ----------------------------------------------------------------------------
module ile_datapath #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned AW       = 8
) (
  input  logic                clk_i,
  input  ile_pkg::dp_cmd_t    cmd_i,
  input  logic [63:0]         item_i,
  input  logic [63:0]         mask_i,
  input  logic [3:0]          off_i,
  input  logic [3:0]          len_i,
  input  logic                str_i,
  output ile_pkg::dp_sts_t    sts_o,
  output logic [63:0]         result_o
);

  logic [63:0] mem_q [CAPACITY];
  logic [63:0] rdata_q;
  logic [63:0] hold_q;
  logic [63:0] res_q;
  logic [63:0] wdata;

  always_comb begin
    case (cmd_i.wr_sel)
      2'd0:    wdata = item_i & mask_i;
      2'd1:    wdata = rdata_q;
      default: wdata = hold_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[cmd_i.wr_addr[AW-1:0]] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem_q[cmd_i.rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_en) hold_q <= rdata_q;
    if (cmd_i.res_zero)     res_q <= '0;
    else if (cmd_i.res_new) res_q <= item_i & mask_i;
    else if (cmd_i.res_en)  res_q <= rdata_q & mask_i;
  end

  // Window compare: byte k of the key against byte off+k of the item.
  always_comb begin
    logic done;
    logic m;
    logic [7:0] a;
    logic [7:0] b;
    logic [2:0] idx;
    done = 1'b0;
    m    = 1'b1;
    for (int k = 0; k < 8; k++) begin
      idx = 3'(off_i) + 3'(k);
      a   = rdata_q[8*idx +: 8];
      b   = item_i[8*k +: 8];
      if (!done && 4'(k) < len_i) begin
        if (a != b) begin
          m    = 1'b0;
          done = 1'b1;
        end else if (str_i && a == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    sts_o.match = m;
  end

  assign result_o = res_q;

endmodule

@@ rtl/ile_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_ctrl: request sequencer
// Checks each request, walks the memory for shifts and searches and keeps
// the count, the last search index and the result fields.
// ----------------------------------------------------------------------------
module ile_ctrl #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic [3:0]               op_i,
  input  logic [7:0]               pa_i,
  input  logic [7:0]               pb_i,
  input  logic [3:0]               nb_i,
  input  logic [3:0]               off_i,
  input  logic [3:0]               len_i,
  output logic [3:0]               len_o,
  output ile_pkg::dp_cmd_t         cmd_o,
  input  ile_pkg::dp_sts_t         sts_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output ile_pkg::status_e         status_o,
  output logic [7:0]               index_o,
  output logic [8:0]               count_o,
  output logic [8:0]               last_o
);

  localparam int unsigned AW = ile_pkg::AddrW;
  localparam logic [AW:0] Cap = (AW+1)'(CAPACITY);

  ile_pkg::state_e  state_q, state_d;
  logic [AW:0]      count_q, count_d;
  logic [8:0]       last_q, last_d;
  logic [AW:0]      ptr_q, ptr_d;
  ile_pkg::status_e status_q, status_d;
  logic [7:0]       index_q, index_d;
  logic [3:0]       len_q, len_d;

  logic [AW:0] pa, pb;
  assign pa = (AW+1)'(pa_i);
  assign pb = (AW+1)'(pb_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ile_pkg::S_IDLE;
      count_q  <= '0;
      last_q   <= '1;
      ptr_q    <= '0;
      status_q <= ile_pkg::ST_OK;
      index_q  <= '0;
      len_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      last_q   <= last_d;
      ptr_q    <= ptr_d;
      status_q <= status_d;
      index_q  <= index_d;
      len_q    <= len_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    last_d   = last_q;
    ptr_d    = ptr_q;
    status_d = status_q;
    index_d  = index_q;
    len_d    = len_q;
    cmd_o    = '0;
    case (state_q)
      ile_pkg::S_IDLE: begin
        if (req_valid_i) state_d = ile_pkg::S_DECODE;
      end
      ile_pkg::S_DECODE: begin
        status_d = ile_pkg::ST_OK;
        index_d  = '0;
        cmd_o.res_zero = 1'b1;
        state_d  = ile_pkg::S_OUT;
        case (op_i)
          ile_pkg::OP_ADD: begin
            if (count_q >= Cap) status_d = ile_pkg::ST_FULL;
            else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_addr = count_q[AW-1:0];
              cmd_o.res_zero = 1'b0;
              cmd_o.res_new = 1'b1;
              index_d = count_q[7:0];
              count_d = count_q + 1'b1;
            end
          end
          ile_pkg::OP_INSERT: begin
            if (pa > count_q) status_d = ile_pkg::ST_RANGE;
            else if (count_q >= Cap) status_d = ile_pkg::ST_FULL;
            else begin
              ptr_d   = count_q;
              state_d = ile_pkg::S_SHIFT_RD;
            end
          end
          ile_pkg::OP_REPLACE: begin
            if (pa >= count_q) status_d = ile_pkg::ST_RANGE;
            else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_addr = pa[AW-1:0];
              cmd_o.res_zero = 1'b0;
              cmd_o.res_new = 1'b1;
              index_d = pa_i;
            end
          end
          ile_pkg::OP_REMOVE, ile_pkg::OP_READ: begin
            if (pa >= count_q) status_d = ile_pkg::ST_RANGE;
            else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = pa[AW-1:0];
              index_d = pa_i;
              ptr_d   = pa;
              state_d = ile_pkg::S_READ;
            end
          end
          ile_pkg::OP_FIRST, ile_pkg::OP_LAST: begin
            last_d = '1;
            if ({1'b0, off_i} + {1'b0, len_i} > {1'b0, nb_i}) begin
              status_d = ile_pkg::ST_WINDOW;
            end else begin
              len_d = (off_i == 4'd0 && len_i == 4'd0) ? nb_i : len_i;
              ptr_d = (op_i == ile_pkg::OP_FIRST) ? '0 : count_q;
              state_d = ile_pkg::S_SEARCH;
            end
          end
          ile_pkg::OP_SWAP: begin
            if (pa >= count_q || pb >= count_q) status_d = ile_pkg::ST_RANGE;
            else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = pa[AW-1:0];
              index_d = pa_i;
              state_d = ile_pkg::S_SWAP_RD;
            end
          end
          ile_pkg::OP_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      // Insert: move entry ptr-1 to ptr, walking down to the position.
      ile_pkg::S_SHIFT_RD: begin
        if (ptr_q == pa) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = pa[AW-1:0];
          cmd_o.res_new = 1'b1;
          index_d = pa_i;
          count_d = count_q + 1'b1;
          state_d = ile_pkg::S_OUT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = AW'(ptr_q - 1'b1);
          state_d = ile_pkg::S_SHIFT_WR;
        end
      end
      ile_pkg::S_SHIFT_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = 2'd1;
        cmd_o.wr_addr = ptr_q[AW-1:0];
        ptr_d   = ptr_q - 1'b1;
        state_d = ile_pkg::S_SHIFT_RD;
      end
      ile_pkg::S_READ: begin
        cmd_o.res_en = 1'b1;
        state_d = (op_i == ile_pkg::OP_REMOVE) ? ile_pkg::S_READ_DONE : ile_pkg::S_OUT;
      end
      // Remove: move entry ptr+1 down to ptr until the end.
      ile_pkg::S_READ_DONE: begin
        if (ptr_q + 1'b1 >= count_q) begin
          count_d = count_q - 1'b1;
          state_d = ile_pkg::S_OUT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = AW'(ptr_q + 1'b1);
          state_d = ile_pkg::S_SWAP_WR;
        end
      end
      ile_pkg::S_SEARCH: begin
        if ((op_i == ile_pkg::OP_FIRST && ptr_q >= count_q) ||
            (op_i == ile_pkg::OP_LAST && ptr_q == '0)) begin
          status_d = ile_pkg::ST_NOMATCH;
          state_d  = ile_pkg::S_OUT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = (op_i == ile_pkg::OP_FIRST) ? ptr_q[AW-1:0] :
                          AW'(ptr_q - 1'b1);
          if (op_i == ile_pkg::OP_LAST) ptr_d = ptr_q - 1'b1;
          state_d = ile_pkg::S_SEARCH_CHK;
        end
      end
      ile_pkg::S_SEARCH_CHK: begin
        if (sts_i.match) begin
          cmd_o.res_en = 1'b1;
          index_d = ptr_q[7:0];
          last_d  = 9'(ptr_q);
          state_d = ile_pkg::S_OUT;
        end else begin
          if (op_i == ile_pkg::OP_FIRST) ptr_d = ptr_q + 1'b1;
          state_d = ile_pkg::S_SEARCH;
        end
      end
      ile_pkg::S_SWAP_RD: begin
        // rdata holds entry pa; keep it and fetch entry pb.
        cmd_o.hold_en = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = pb[AW-1:0];
        ptr_d   = '0;
        state_d = ile_pkg::S_SWAP_WR;
      end
      // Shared by swap (two writes) and remove (one write per step).
      ile_pkg::S_SWAP_WR: begin
        if (op_i == ile_pkg::OP_REMOVE) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = 2'd1;
          cmd_o.wr_addr = ptr_q[AW-1:0];
          ptr_d   = ptr_q + 1'b1;
          state_d = ile_pkg::S_READ_DONE;
        end else if (ptr_q == '0) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = 2'd1;
          cmd_o.wr_addr = pa[AW-1:0];
          cmd_o.res_en  = 1'b1;
          ptr_d = '1;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = 2'd2;
          cmd_o.wr_addr = pb[AW-1:0];
          state_d = ile_pkg::S_OUT;
        end
      end
      ile_pkg::S_OUT: begin
        if (res_ready_i) state_d = ile_pkg::S_IDLE;
      end
      default: state_d = ile_pkg::S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == ile_pkg::S_OUT) && res_ready_i;
  assign res_valid_o = (state_q == ile_pkg::S_OUT);
  assign status_o    = status_q;
  assign index_o     = index_q;
  assign count_o     = 9'(count_q);
  assign last_o      = last_q;
  assign len_o       = len_q;

endmodule

@@ sim/indexed_list_engine_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_checker: result scoreboard of the indexed list engine
// Watches the request, result and APB channels, keeps its own copy of the
// list, the item size and the last search index, and compares every result
// word field by field with the expected one.
// ----------------------------------------------------------------------------
module indexed_list_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // op[3:0], position[11:4], position_b[19:12], item_data[83:20],
  // match_offset[87:84], match_length[91:88], string_compare[92], zeros
  input  logic [95:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // status[2:0], result_item[66:3], result_index[74:67], entry_count[83:75],
  // last_search_index[92:84], zeros
  input  logic [95:0] m_axis_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);

  // Members run from the highest bits of the result word down to bit 0.
  typedef struct packed {
    logic [8:0]  last_hit;
    logic [8:0]  count;
    logic [7:0]  index;
    logic [63:0] item;
    logic [2:0]  status;
  } list_result_t;

  logic [63:0]  list_store [256];
  int unsigned  list_len;
  logic [8:0]   last_hit;
  logic [3:0]   size_cfg;
  list_result_t expected_results [$];

  function automatic int unsigned size_bytes();
    int unsigned b;
    b = 32'(size_cfg);
    if (b == 0) b = 1;
    if (b > 8) b = 8;
    return b;
  endfunction

  function automatic logic [63:0] size_mask();
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) if (k < size_bytes()) m[8*k +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic bit window_hit(input logic [63:0] entry, input logic [63:0] key,
                                    input int unsigned off, input int unsigned len,
                                    input bit str);
    logic [7:0] a, b;
    for (int unsigned k = 0; k < len; k++) begin
      a = entry[8*((off + k) & 7) +: 8];
      b = key[8*k +: 8];
      if (a != b) return 0;
      if (str && a == 8'h00) return 1;
    end
    return 1;
  endfunction

  // Applies one request to the shadow list and returns the result it causes.
  function automatic list_result_t apply_request(input logic [95:0] req);
    list_result_t r;
    logic [3:0]   op;
    int unsigned  pa, pb, off, len, nb, hit;
    logic [63:0]  data, m, t;
    bit           str, found;
    op = req[3:0];
    pa = 32'(req[11:4]);
    pb = 32'(req[19:12]);
    data = req[83:20];
    off = 32'(req[87:84]);
    len = 32'(req[91:88]);
    str = req[92];
    m = size_mask();
    r = '0;
    r.status = ile_pkg::ST_OK;
    case (op)
      ile_pkg::OP_ADD: begin
        if (list_len >= 256) r.status = ile_pkg::ST_FULL;
        else begin
          list_store[list_len] = data & m;
          r.item = data & m;
          r.index = list_len[7:0];
          list_len++;
        end
      end
      ile_pkg::OP_INSERT: begin
        if (pa > list_len) r.status = ile_pkg::ST_RANGE;
        else if (list_len >= 256) r.status = ile_pkg::ST_FULL;
        else begin
          for (int unsigned i = list_len; i > pa; i--) list_store[i] = list_store[i-1];
          list_store[pa] = data & m;
          r.item = data & m;
          r.index = pa[7:0];
          list_len++;
        end
      end
      ile_pkg::OP_REPLACE: begin
        if (pa >= list_len) r.status = ile_pkg::ST_RANGE;
        else begin
          list_store[pa] = data & m;
          r.item = data & m;
          r.index = pa[7:0];
        end
      end
      ile_pkg::OP_REMOVE: begin
        if (pa >= list_len) r.status = ile_pkg::ST_RANGE;
        else begin
          r.item = list_store[pa] & m;
          r.index = pa[7:0];
          for (int unsigned i = pa; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
          list_len--;
        end
      end
      ile_pkg::OP_READ: begin
        if (pa >= list_len) r.status = ile_pkg::ST_RANGE;
        else begin
          r.item = list_store[pa] & m;
          r.index = pa[7:0];
        end
      end
      ile_pkg::OP_FIRST, ile_pkg::OP_LAST: begin
        nb = size_bytes();
        found = 0;
        hit = 0;
        last_hit = '1;
        if (off + len > nb) r.status = ile_pkg::ST_WINDOW;
        else begin
          if (off == 0 && len == 0) len = nb;
          if (op == ile_pkg::OP_FIRST) begin
            for (int unsigned i = 0; i < list_len && !found; i++)
              if (window_hit(list_store[i], data, off, len, str)) begin
                found = 1;
                hit = i;
              end
          end else begin
            for (int i = int'(list_len) - 1; i >= 0 && !found; i--)
              if (window_hit(list_store[i], data, off, len, str)) begin
                found = 1;
                hit = 32'(i);
              end
          end
          if (!found) r.status = ile_pkg::ST_NOMATCH;
          else begin
            last_hit = hit[8:0];
            r.item = list_store[hit] & m;
            r.index = hit[7:0];
          end
        end
      end
      ile_pkg::OP_SWAP: begin
        if (pa >= list_len || pb >= list_len) r.status = ile_pkg::ST_RANGE;
        else begin
          t = list_store[pa];
          list_store[pa] = list_store[pb];
          list_store[pb] = t;
          r.item = list_store[pa] & m;
          r.index = pa[7:0];
        end
      end
      ile_pkg::OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = list_len[8:0];
    r.last_hit = last_hit;
    return r;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t exp_r, got;
    if (!rst_ni) begin
      list_len = 0;
      last_hit = '1;
      size_cfg = 4'd8;
      expected_results.delete();
      fail_count_o = 0;
      results_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == 2'd0)
        size_cfg = pwdata_i[3:0];
      // The request is taken in the same cycle as its own result word.
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_results.push_back(apply_request(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[92:0];
        results_o++;
        if (expected_results.size() == 0) begin
          $error("result word with no request outstanding: %h", m_axis_tdata_i);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            fail_count_o++;
          end
          if (got.item !== exp_r.item) begin
            $error("result_item: expected %h, got %h", exp_r.item, got.item);
            fail_count_o++;
          end
          if (got.index !== exp_r.index) begin
            $error("result_index: expected %0d, got %0d", exp_r.index, got.index);
            fail_count_o++;
          end
          if (got.count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, got.count);
            fail_count_o++;
          end
          if (got.last_hit !== exp_r.last_hit) begin
            $error("last_search_index: expected %h, got %h", exp_r.last_hit, got.last_hit);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

@@ sim/tb_indexed_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_engine: stimulus and verdict for the indexed list engine
// Runs directed requests for every operation and corner case, then random
// requests under several item sizes, with bursty requests, random result
// stalls, and one pass that fills the list to capacity.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, results;
  int          sent = 0, burst_left = 0, stall_mode = 0, stall_cnt = 0;
  logic [63:0] key_pool [$];

  always #10 clk_i = ~clk_i;

  indexed_list_engine u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o(m_axis_tdata),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  indexed_list_engine_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i(m_axis_tdata),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  // Result stalls: the mode is redrawn whenever its counter runs out.
  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt <= $urandom_range(50, 400);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic send_req(input logic [3:0] op, input int unsigned pos,
                          input int unsigned pos_b, input logic [63:0] data,
                          input int unsigned off, input int unsigned len, input bit str);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i) s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b0, str, len[3:0], off[3:0], data, pos_b[7:0], pos[7:0], op};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sent++;
    if (op == ile_pkg::OP_ADD || op == ile_pkg::OP_INSERT || op == ile_pkg::OP_REPLACE) begin
      key_pool.push_back(data);
      if (key_pool.size() > 16) void'(key_pool.pop_front());
    end
  endtask

  // Stops requests and waits until the engine is idle.
  task automatic drain();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_item_size(input logic [3:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= {28'b0, value};
    @(negedge clk_i) penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] pick_data();
    logic [63:0] v;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && key_pool.size() != 0) begin
      v = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if ($urandom_range(0, 3) == 0) v[8*$urandom_range(0, 7) +: 8] = 8'($urandom);
    end else if (r < 7) begin
      for (int k = 0; k < 8; k++)
        case ($urandom_range(0, 3))
          0: v[8*k +: 8] = 8'h00;
          1: v[8*k +: 8] = 8'h41;
          2: v[8*k +: 8] = 8'h42;
          default: v[8*k +: 8] = 8'hFF;
        endcase
    end else begin
      v = {$urandom, $urandom};
    end
    return v;
  endfunction

  task automatic random_req();
    int unsigned r, pos, pos_b, off, len;
    logic [3:0]  op;
    r = $urandom_range(0, 99);
    if (r < 25) op = ile_pkg::OP_ADD;
    else if (r < 35) op = ile_pkg::OP_INSERT;
    else if (r < 42) op = ile_pkg::OP_REPLACE;
    else if (r < 50) op = ile_pkg::OP_REMOVE;
    else if (r < 58) op = ile_pkg::OP_READ;
    else if (r < 68) op = ile_pkg::OP_FIRST;
    else if (r < 78) op = ile_pkg::OP_LAST;
    else if (r < 86) op = ile_pkg::OP_SWAP;
    else if (r < 88) op = ile_pkg::OP_CLEAR;
    else if (r < 90) op = 4'($urandom_range(9, 15));
    else op = ile_pkg::OP_ADD;
    pos = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 48);
    pos_b = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 48);
    if ($urandom_range(0, 4) == 0) begin
      off = $urandom_range(0, 15);
      len = $urandom_range(0, 15);
    end else begin
      off = $urandom_range(0, 3);
      len = $urandom_range(0, 8 - off);
    end
    send_req(op, pos, pos_b, pick_data(), off, len, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [3:0] sizes [7];
    sizes = '{4'd8, 4'd1, 4'd0, 4'd3, 4'd15, 4'd5, 4'd8};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed corner cases at the reset item size.
    send_req(ile_pkg::OP_FIRST, 0, 0, 64'h0, 0, 0, 0);               // empty list
    send_req(ile_pkg::OP_READ, 0, 0, 64'h0, 0, 0, 0);                // read of empty list
    send_req(ile_pkg::OP_ADD, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    send_req(ile_pkg::OP_ADD, 0, 0, 64'h0, 0, 0, 0);
    send_req(ile_pkg::OP_ADD, 0, 0, 64'h0000_0000_0042_4141, 0, 0, 0);
    send_req(ile_pkg::OP_INSERT, 3, 0, 64'h1234_5678_9ABC_DEF0, 0, 0, 0); // insert at end
    send_req(ile_pkg::OP_INSERT, 9, 0, 64'h1, 0, 0, 0);              // beyond the end
    send_req(ile_pkg::OP_INSERT, 0, 0, 64'h00FF_0041_4100_4241, 0, 0, 0);
    send_req(ile_pkg::OP_REPLACE, 4, 0, 64'h8000_0000_0000_0001, 0, 0, 0);
    send_req(ile_pkg::OP_REPLACE, 255, 0, 64'h5, 0, 0, 0);
    send_req(ile_pkg::OP_READ, 2, 0, 64'h0, 0, 0, 0);
    send_req(ile_pkg::OP_FIRST, 0, 0, 64'h0000_0000_0042_41FF, 0, 3, 1); // string compare, no hit
    send_req(ile_pkg::OP_LAST, 0, 0, 64'h0, 2, 0, 0);                // zero length window
    send_req(ile_pkg::OP_FIRST, 0, 0, 64'h0, 5, 4, 0);               // window too wide
    send_req(ile_pkg::OP_LAST, 0, 0, 64'hDEAD, 0, 2, 0);             // no match
    send_req(ile_pkg::OP_SWAP, 1, 1, 64'h0, 0, 0, 0);
    send_req(ile_pkg::OP_SWAP, 0, 4, 64'h0, 0, 0, 0);
    send_req(ile_pkg::OP_SWAP, 2, 200, 64'h0, 0, 0, 0);
    send_req(ile_pkg::OP_REMOVE, 1, 0, 64'h0, 0, 0, 0);
    send_req(ile_pkg::OP_REMOVE, 4, 0, 64'h0, 0, 0, 0);
    send_req(4'd15, 0, 0, 64'h0, 15, 15, 1);                         // unused code
    send_req(ile_pkg::OP_LAST, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
    send_req(ile_pkg::OP_CLEAR, 0, 0, 64'h0, 0, 0, 0);               // keeps last index
    send_req(ile_pkg::OP_READ, 0, 0, 64'h0, 0, 0, 0);

    foreach (sizes[s]) begin
      drain();
      write_item_size(sizes[s]);
      repeat (230) random_req();
      if (s == 3) begin
        // Fill to capacity, then push against the full list.
        send_req(ile_pkg::OP_CLEAR, 0, 0, 64'h0, 0, 0, 0);
        repeat (258) send_req(ile_pkg::OP_ADD, 0, 0, pick_data(), 0, 0, 0);
        send_req(ile_pkg::OP_INSERT, 0, 0, 64'h77, 0, 0, 0);
        send_req(ile_pkg::OP_INSERT, 255, 0, 64'h77, 0, 0, 0);
        send_req(ile_pkg::OP_LAST, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 0);
        send_req(ile_pkg::OP_SWAP, 0, 255, 64'h0, 0, 0, 0);
        send_req(ile_pkg::OP_READ, 255, 0, 64'h0, 0, 0, 0);
        send_req(ile_pkg::OP_REMOVE, 0, 0, 64'h0, 0, 0, 0);
        send_req(ile_pkg::OP_CLEAR, 0, 0, 64'h0, 0, 0, 0);
      end
    end

    drain();
    repeat (600) @(posedge clk_i);
    $display("Sent %0d requests over 7 item-size settings including a full-list pass;", sent);
    $display("checked %0d result words.", results);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
